// ===== rtl/snv_pkg.sv =====
// ============================================================================
// snv_pkg
// Shared types, widths, edge tables and register indexes for the surface
// nets cell vertex block.
// ============================================================================
package snv_pkg;

    localparam int NUM_CORNERS  = 8;
    localparam int NUM_EDGES    = 12;
    localparam int NUM_AXES     = 3;
    localparam int FRAC_BITS    = 16;
    localparam int T_WIDTH      = 17;
    localparam int SUM_WIDTH    = 20;
    localparam int CNT_WIDTH    = 4;
    localparam int CELL_WIDTH   = 5;
    localparam int ORIGIN_WIDTH = 11;
    localparam int SCALE_WIDTH  = 16;
    localparam int VERT_WIDTH   = 32;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int OUT_FIELDS_W = 1 + CNT_WIDTH + NUM_AXES * VERT_WIDTH;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [T_WIDTH-1:0]   T_HALF   = T_WIDTH'(32768);
    localparam logic [SUM_WIDTH-1:0] ONE_CELL = SUM_WIDTH'(65536);

    typedef logic [2:0] corner_t;
    typedef logic [1:0] axis_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_ORIGIN_X = 2'd0;
    localparam cfg_addr_t REG_ORIGIN_Y = 2'd1;
    localparam cfg_addr_t REG_ORIGIN_Z = 2'd2;
    localparam cfg_addr_t REG_SCALE    = 2'd3;

    // Edges as (low corner, axis); high corner = low | (1 << axis).
    localparam corner_t EDGE_LOW [NUM_EDGES] = '{
        3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3
    };
    localparam axis_t EDGE_AXIS [NUM_EDGES] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
    };

    typedef struct packed {
        logic [CELL_WIDTH-1:0] z;
        logic [CELL_WIDTH-1:0] y;
        logic [CELL_WIDTH-1:0] x;
    } cell_t;

    typedef struct packed {
        logic signed [ORIGIN_WIDTH-1:0] origin_x;
        logic signed [ORIGIN_WIDTH-1:0] origin_y;
        logic signed [ORIGIN_WIDTH-1:0] origin_z;
        logic [SCALE_WIDTH-1:0]         scale;
    } cfg_t;

    // Edges off the given axis whose low corner sits on the far face of it.
    function automatic logic [NUM_EDGES-1:0] far_face_mask(input int axis);
        logic [NUM_EDGES-1:0] m;
        m = '0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            m[e] = (int'(EDGE_AXIS[e]) != axis) && EDGE_LOW[e][axis];
        end
        return m;
    endfunction

endpackage

// ===== rtl/surface_nets_cell_vertex.sv =====
// ============================================================================
// surface_nets_cell_vertex
// Surface nets vertex placement for one distance-field cell per transaction.
//
//   channel  | direction | contents
//   s_*      | in        | cell coordinates and eight corner distances
//   m_*      | out       | found flag, crossing count, world vertex x/y/z
//   cfg_*    | in        | chunk origin x/y/z and cell scale writes
//
// Data passes the edge fraction dividers (one quotient bit per stage), the
// average divider, then scaling and saturation. One transaction per cycle
// is sustained while m_tready is high. Reset clears only valid bits and the
// origins, and sets scale to 256. A stall on m_* holds the output register;
// earlier stages keep filling bubbles; s_tready drops only when all are full.
// ============================================================================
module surface_nets_cell_vertex #(
    parameter int RESOLUTION = 32,
    parameter int DIST_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cell_x, cell_y, cell_z, dist_000, dist_100, dist_010, dist_110,
    // dist_001, dist_101, dist_011, dist_111
    input  logic [((15 + 8 * DIST_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vertex_found, crossing_count, vertex_x, vertex_y, vertex_z
    output logic [snv_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             cfg_we,
    input  logic [snv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [snv_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
    import snv_pkg::*;

    localparam int DIST_BASE = 3 * CELL_WIDTH;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    cell_t                        in_cell;
    logic signed [DIST_WIDTH-1:0] in_dist [NUM_CORNERS];

    logic                 cd_valid;
    logic                 cd_ready;
    cell_t                cd_cell;
    logic [NUM_EDGES-1:0] cd_mask;
    logic [T_WIDTH-1:0]   cd_t [NUM_EDGES];

    logic                 av_valid;
    logic                 av_ready;
    cell_t                av_cell;
    logic [CNT_WIDTH-1:0] av_count;
    logic [T_WIDTH-1:0]   av_avg [NUM_AXES];

    logic                  w_found;
    logic [CNT_WIDTH-1:0]  w_count;
    logic [VERT_WIDTH-1:0] w_vertex [NUM_AXES];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_ORIGIN_X: cfg_next.origin_x = cfg_wdata[ORIGIN_WIDTH-1:0];
                REG_ORIGIN_Y: cfg_next.origin_y = cfg_wdata[ORIGIN_WIDTH-1:0];
                REG_ORIGIN_Z: cfg_next.origin_z = cfg_wdata[ORIGIN_WIDTH-1:0];
                REG_SCALE:    cfg_next.scale    = cfg_wdata[SCALE_WIDTH-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.scale    <= SCALE_WIDTH'(256);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_cell.x = s_tdata[CELL_WIDTH-1:0];
    assign in_cell.y = s_tdata[2*CELL_WIDTH-1:CELL_WIDTH];
    assign in_cell.z = s_tdata[3*CELL_WIDTH-1:2*CELL_WIDTH];

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            in_dist[i] = s_tdata[DIST_BASE + i * DIST_WIDTH +: DIST_WIDTH];
        end
    end

    snv_cross_div #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_cross_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cell   (in_cell),
        .in_dist   (in_dist),
        .out_valid (cd_valid),
        .out_ready (cd_ready),
        .out_cell  (cd_cell),
        .out_mask  (cd_mask),
        .out_t     (cd_t)
    );

    snv_avg_div u_avg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cd_valid),
        .in_ready  (cd_ready),
        .in_cell   (cd_cell),
        .in_mask   (cd_mask),
        .in_t      (cd_t),
        .out_valid (av_valid),
        .out_ready (av_ready),
        .out_cell  (av_cell),
        .out_count (av_count),
        .out_avg   (av_avg)
    );

    snv_world #(
        .RESOLUTION (RESOLUTION)
    ) u_world (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (av_valid),
        .in_ready   (av_ready),
        .in_cell    (av_cell),
        .in_count   (av_count),
        .in_avg     (av_avg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (w_found),
        .out_count  (w_count),
        .out_vertex (w_vertex)
    );

    assign m_tdata = {
        (OUT_W - OUT_FIELDS_W)'(0),
        w_vertex[2], w_vertex[1], w_vertex[0], w_count, w_found
    };

endmodule

// ===== rtl/snv_cross_div.sv =====
// ============================================================================
// snv_cross_div
// Edge sign test and crossing fraction |e1| / (|e1| + |e2|) in Q1.16 for all
// twelve cube edges, one quotient bit per pipeline stage.
// ============================================================================
module snv_cross_div #(
    parameter int DIST_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  snv_pkg::cell_t                     in_cell,
    input  logic signed [DIST_WIDTH-1:0]       in_dist [snv_pkg::NUM_CORNERS],
    output logic                               out_valid,
    input  logic                               out_ready,
    output snv_pkg::cell_t                     out_cell,
    output logic [snv_pkg::NUM_EDGES-1:0]      out_mask,
    output logic [snv_pkg::T_WIDTH-1:0]        out_t [snv_pkg::NUM_EDGES]
);
    import snv_pkg::*;

    localparam int NST   = T_WIDTH + 1;
    localparam int MAG_W = DIST_WIDTH;
    localparam int DEN_W = DIST_WIDTH + 1;
    localparam int REM_W = DIST_WIDTH + 2;

    logic [NST-1:0]       valid_reg;
    logic [NST:0]         en;
    cell_t                cell_reg [NST];
    logic [NUM_EDGES-1:0] mask_reg [NST];
    logic [NUM_EDGES-1:0] zero_reg [NST];
    logic [DEN_W-1:0]     den_reg  [NST][NUM_EDGES];
    logic [REM_W-1:0]     rem_reg  [NST][NUM_EDGES];
    logic [T_WIDTH-1:0]   quo_reg  [NST][NUM_EDGES];

    logic [NUM_EDGES-1:0] mask_next;
    logic [NUM_EDGES-1:0] zero_next;
    logic [DEN_W-1:0]     den_next [NUM_EDGES];
    logic [REM_W-1:0]     rem_next [NUM_EDGES];

    assign in_ready = en[0];

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        logic signed [DIST_WIDTH-1:0] e1;
        logic signed [DIST_WIDTH-1:0] e2;
        logic [MAG_W-1:0]             m1;
        logic [MAG_W-1:0]             m2;
        for (int e = 0; e < NUM_EDGES; e++) begin
            e1 = in_dist[EDGE_LOW[e]];
            e2 = in_dist[EDGE_LOW[e] | corner_t'(3'd1 << EDGE_AXIS[e])];
            m1 = e1[DIST_WIDTH-1] ? MAG_W'(~e1) + MAG_W'(1) : MAG_W'(e1);
            m2 = e2[DIST_WIDTH-1] ? MAG_W'(~e2) + MAG_W'(1) : MAG_W'(e2);
            mask_next[e] = ((e1[DIST_WIDTH-1] || (e1 == '0)) && !e2[DIST_WIDTH-1])
                        || (!e1[DIST_WIDTH-1] && (e2[DIST_WIDTH-1] || (e2 == '0)));
            zero_next[e] = (e1 == '0) && (e2 == '0);
            den_next[e]  = DEN_W'(m1) + DEN_W'(m2);
            rem_next[e]  = REM_W'(m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            cell_reg[0] <= in_cell;
            mask_reg[0] <= mask_next;
            zero_reg[0] <= zero_next;
            for (int e = 0; e < NUM_EDGES; e++) begin
                den_reg[0][e] <= den_next[e];
                rem_reg[0][e] <= rem_next[e];
                quo_reg[0][e] <= '0;
            end
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_step
        logic [REM_W-1:0]   r_c   [NUM_EDGES];
        logic [REM_W-1:0]   rem_c [NUM_EDGES];
        logic [T_WIDTH-1:0] quo_c [NUM_EDGES];

        always_comb
        begin
            logic ge;
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_c[e]   = (k == 1) ? rem_reg[k-1][e] : (rem_reg[k-1][e] << 1);
                ge       = r_c[e] >= REM_W'(den_reg[k-1][e]);
                rem_c[e] = ge ? r_c[e] - REM_W'(den_reg[k-1][e]) : r_c[e];
                quo_c[e] = {quo_reg[k-1][e][T_WIDTH-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k]) begin
                cell_reg[k] <= cell_reg[k-1];
                mask_reg[k] <= mask_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                for (int e = 0; e < NUM_EDGES; e++) begin
                    den_reg[k][e] <= den_reg[k-1][e];
                    rem_reg[k][e] <= rem_c[e];
                    quo_reg[k][e] <= quo_c[e];
                end
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_cell  = cell_reg[NST-1];
    assign out_mask  = mask_reg[NST-1];

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            out_t[e] = zero_reg[NST-1][e] ? T_HALF : quo_reg[NST-1][e];
        end
    end

endmodule

// ===== rtl/snv_avg_div.sv =====
// ============================================================================
// snv_avg_div
// Per-axis sum of crossing offsets and division by the crossing count,
// four quotient bits per pipeline stage.
// ============================================================================
module snv_avg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  snv_pkg::cell_t                in_cell,
    input  logic [snv_pkg::NUM_EDGES-1:0] in_mask,
    input  logic [snv_pkg::T_WIDTH-1:0]   in_t [snv_pkg::NUM_EDGES],
    output logic                          out_valid,
    input  logic                          out_ready,
    output snv_pkg::cell_t                out_cell,
    output logic [snv_pkg::CNT_WIDTH-1:0] out_count,
    output logic [snv_pkg::T_WIDTH-1:0]   out_avg [snv_pkg::NUM_AXES]
);
    import snv_pkg::*;

    localparam int STEPS = 4;
    localparam int NDIV  = SUM_WIDTH / STEPS;
    localparam int NST   = NDIV + 1;

    logic [NST-1:0]       valid_reg;
    logic [NST:0]         en;
    cell_t                cell_reg  [NST];
    logic [CNT_WIDTH-1:0] count_reg [NST];
    logic [SUM_WIDTH-1:0] num_reg   [NST][NUM_AXES];
    logic [CNT_WIDTH-1:0] rem_reg   [NST][NUM_AXES];

    logic [SUM_WIDTH-1:0] sum_next [NUM_AXES];
    logic [CNT_WIDTH-1:0] count_next;

    assign in_ready = en[0];

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        logic [SUM_WIDTH-1:0] acc;
        logic [CNT_WIDTH-1:0] nfar;
        for (int a = 0; a < NUM_AXES; a++) begin
            nfar = CNT_WIDTH'($countones(in_mask & far_face_mask(a)));
            acc  = SUM_WIDTH'(nfar) << FRAC_BITS;
            for (int e = 0; e < NUM_EDGES; e++) begin
                if ((int'(EDGE_AXIS[e]) == a) && in_mask[e]) begin
                    acc = acc + SUM_WIDTH'(in_t[e]);
                end
            end
            sum_next[a] = acc;
        end
        count_next = CNT_WIDTH'($countones(in_mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            cell_reg[0]  <= in_cell;
            count_reg[0] <= count_next;
            for (int a = 0; a < NUM_AXES; a++) begin
                num_reg[0][a] <= sum_next[a];
                rem_reg[0][a] <= '0;
            end
        end
    end

    for (genvar s = 1; s < NST; s++) begin : g_div
        logic [SUM_WIDTH-1:0] num_c [NUM_AXES];
        logic [CNT_WIDTH-1:0] rem_c [NUM_AXES];

        always_comb
        begin
            logic [CNT_WIDTH:0] r;
            logic [CNT_WIDTH:0] d;
            d = {1'b0, count_reg[s-1]};
            for (int a = 0; a < NUM_AXES; a++) begin
                num_c[a] = num_reg[s-1][a];
                rem_c[a] = rem_reg[s-1][a];
                for (int j = 0; j < STEPS; j++) begin
                    r        = {rem_c[a], num_c[a][SUM_WIDTH-1]};
                    num_c[a] = num_c[a] << 1;
                    if (r >= d) begin
                        rem_c[a]    = CNT_WIDTH'(r - d);
                        num_c[a][0] = 1'b1;
                    end else begin
                        rem_c[a] = r[CNT_WIDTH-1:0];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s]) begin
                cell_reg[s]  <= cell_reg[s-1];
                count_reg[s] <= count_reg[s-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    num_reg[s][a] <= num_c[a];
                    rem_reg[s][a] <= rem_c[a];
                end
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_cell  = cell_reg[NST-1];
    assign out_count = count_reg[NST-1];

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++) begin
            out_avg[a] = num_reg[NST-1][a][T_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/snv_world.sv =====
// ============================================================================
// snv_world
// Cell position plus average, scaled to world units, rounded to Q.8 and
// saturated to 32 bits; holds the output register.
// ============================================================================
module snv_world #(
    parameter int RESOLUTION = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  snv_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  snv_pkg::cell_t                in_cell,
    input  logic [snv_pkg::CNT_WIDTH-1:0] in_count,
    input  logic [snv_pkg::T_WIDTH-1:0]   in_avg [snv_pkg::NUM_AXES],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_found,
    output logic [snv_pkg::CNT_WIDTH-1:0] out_count,
    output logic [snv_pkg::VERT_WIDTH-1:0] out_vertex [snv_pkg::NUM_AXES]
);
    import snv_pkg::*;

    localparam int NST  = 4;
    localparam int PW   = ORIGIN_WIDTH + $clog2(RESOLUTION) + 2;
    localparam int MH_W = PW + SCALE_WIDTH + 1;
    localparam int ML_W = T_WIDTH + SCALE_WIDTH;
    localparam int PR_W = MH_W + FRAC_BITS + 1;
    localparam int QW   = PR_W - FRAC_BITS;

    logic [NST-1:0]       valid_reg;
    logic [NST:0]         en;
    logic [CNT_WIDTH-1:0] count_reg [NST];

    logic signed [PW-1:0]   pos_reg  [NUM_AXES];
    logic [T_WIDTH-1:0]     avg_reg  [NUM_AXES];
    logic signed [MH_W-1:0] mh_reg   [NUM_AXES];
    logic [ML_W-1:0]        ml_reg   [NUM_AXES];
    logic signed [QW-1:0]   q_reg    [NUM_AXES];
    logic [VERT_WIDTH-1:0]  vert_reg [NUM_AXES];

    logic signed [PW-1:0]   pos_next  [NUM_AXES];
    logic signed [MH_W-1:0] mh_next   [NUM_AXES];
    logic [ML_W-1:0]        ml_next   [NUM_AXES];
    logic signed [QW-1:0]   q_next    [NUM_AXES];
    logic [VERT_WIDTH-1:0]  vert_next [NUM_AXES];

    logic signed [ORIGIN_WIDTH-1:0] origin [NUM_AXES];
    logic [CELL_WIDTH-1:0]          cellv  [NUM_AXES];
    logic signed [SCALE_WIDTH:0]    scale_s;

    assign origin[0] = cfg.origin_x;
    assign origin[1] = cfg.origin_y;
    assign origin[2] = cfg.origin_z;
    assign cellv[0]  = in_cell.x;
    assign cellv[1]  = in_cell.y;
    assign cellv[2]  = in_cell.z;
    assign scale_s   = {1'b0, cfg.scale};

    assign in_ready = en[0];

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        logic signed [PR_W-1:0]      prod;
        logic [QW-1:VERT_WIDTH-1]    top;
        for (int a = 0; a < NUM_AXES; a++) begin
            pos_next[a] = PW'(origin[a]) * PW'(RESOLUTION) + PW'(cellv[a]);
            mh_next[a]  = MH_W'(pos_reg[a]) * MH_W'(scale_s);
            ml_next[a]  = ML_W'(avg_reg[a]) * ML_W'(cfg.scale);
            prod        = (PR_W'(mh_reg[a]) <<< FRAC_BITS) + PR_W'(ml_reg[a])
                        + PR_W'(32768);
            q_next[a]   = QW'(prod >>> FRAC_BITS);
            top         = q_reg[a][QW-1:VERT_WIDTH-1];
            if (count_reg[2] == '0) begin
                vert_next[a] = '0;
            end else if ((&top) || !(|top)) begin
                vert_next[a] = q_reg[a][VERT_WIDTH-1:0];
            end else if (q_reg[a][QW-1]) begin
                vert_next[a] = {1'b1, {(VERT_WIDTH-1){1'b0}}};
            end else begin
                vert_next[a] = {1'b0, {(VERT_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            count_reg[0] <= in_count;
            for (int a = 0; a < NUM_AXES; a++) begin
                pos_reg[a] <= pos_next[a];
                avg_reg[a] <= in_avg[a];
            end
        end
        if (en[1]) begin
            count_reg[1] <= count_reg[0];
            for (int a = 0; a < NUM_AXES; a++) begin
                mh_reg[a] <= mh_next[a];
                ml_reg[a] <= ml_next[a];
            end
        end
        if (en[2]) begin
            count_reg[2] <= count_reg[1];
            for (int a = 0; a < NUM_AXES; a++) begin
                q_reg[a] <= q_next[a];
            end
        end
        if (en[3]) begin
            count_reg[3] <= count_reg[2];
            for (int a = 0; a < NUM_AXES; a++) begin
                vert_reg[a] <= vert_next[a];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_count = count_reg[NST-1];
    assign out_found = count_reg[NST-1] != '0;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++) begin
            out_vertex[a] = vert_reg[a];
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Checks surface_nets_cell_vertex: random and directed cells stream in with
// random gaps and output stalls. An in-bench vertex predictor computes each
// expected result, and the results are compared in order, field by field.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import snv_pkg::*;

    localparam int IN_W = 144;

    typedef struct {
        logic        found;
        logic [3:0]  cnt;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } vertex_t;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 0;
    cfg_addr_t        cfg_addr = REG_ORIGIN_X;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    logic [IN_W-1:0] cell_queue[$];
    vertex_t         vertex_queue[$];
    longint          origin[3];
    longint          scale;
    int              errors = 0;
    int              accepted = 0;
    int              tx_gap = 0;
    int              rx_gap = 0;
    logic            burst = 0;
    logic            rx_hold = 0;

    surface_nets_cell_vertex dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    function automatic logic [31:0] to_world(longint org, longint cell_idx, longint avg);
        longint pos, prod, q;
        pos = (org * 32 + cell_idx) * 65536 + avg;
        prod = pos * scale;
        q = (prod + 32768) >>> 16;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic vertex_t place_vertex(logic [IN_W-1:0] pkt);
        vertex_t r;
        longint d[8];
        longint sum[3];
        longint t, m1, m2, e1, e2;
        int cnt, lo, ax, hi;
        cnt = 0;
        for (int a = 0; a < 3; a++) sum[a] = 0;
        for (int i = 0; i < 8; i++) d[i] = longint'($signed(pkt[15 + 16 * i +: 16]));
        for (int e = 0; e < NUM_EDGES; e++) begin
            lo = int'(EDGE_LOW[e]);
            ax = int'(EDGE_AXIS[e]);
            hi = (lo + (1 << ax)) & 7;
            e1 = d[lo];
            e2 = d[hi];
            if (!((e1 <= 0 && e2 >= 0) || (e1 >= 0 && e2 <= 0))) continue;
            m1 = e1 < 0 ? -e1 : e1;
            m2 = e2 < 0 ? -e2 : e2;
            if (e1 == 0 && e2 == 0) t = 32768;
            else t = (m1 << 16) / (m1 + m2);
            for (int a = 0; a < 3; a++) begin
                if (a == ax) sum[a] += t;
                else if ((lo >> a) & 1) sum[a] += 65536;
            end
            cnt++;
        end
        r.found = cnt != 0;
        r.cnt = cnt[3:0];
        if (cnt == 0) begin
            r.vx = 0; r.vy = 0; r.vz = 0;
        end else begin
            r.vx = to_world(origin[0], longint'(pkt[4:0]), sum[0] / cnt);
            r.vy = to_world(origin[1], longint'(pkt[9:5]), sum[1] / cnt);
            r.vz = to_world(origin[2], longint'(pkt[14:10]), sum[2] / cnt);
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_cell(int cx, int cy, int cz, int d[8]);
        logic [IN_W-1:0] p;
        p = '0;
        p[4:0] = cx[4:0];
        p[9:5] = cy[4:0];
        p[14:10] = cz[4:0];
        for (int i = 0; i < 8; i++) p[15 + 16 * i +: 16] = d[i][15:0];
        return p;
    endfunction

    function automatic int rand_dist(int mode);
        int pick;
        case (mode)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 8)) - 4;
            2: begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return int'($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    task automatic push_random(int n);
        int d[8];
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++) d[i] = rand_dist(mode);
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 8; i++) d[i] = int'($urandom_range(1, 32767));
            cell_queue.push_back(pack_cell($urandom_range(0, 31), $urandom_range(0, 31),
                                           $urandom_range(0, 31), d));
        end
    endtask

    task automatic wait_idle();
        while (cell_queue.size() != 0 || vertex_queue.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_addr_t idx, int value);
        @(posedge clk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= value[15:0];
        if (idx == REG_SCALE) scale = longint'(value[15:0]);
        else origin[idx] = longint'($signed(value[10:0]));
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_config(int ox, int oy, int oz, int sc);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_SCALE, sc);
    endtask

    // input side: drive and predict
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            vertex_queue.push_back(place_vertex(s_tdata));
            accepted++;
        end
        if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 0;
            end else if (rst_n && cell_queue.size() != 0) begin
                s_tdata <= cell_queue.pop_front();
                s_tvalid <= 1;
                if ($urandom_range(0, 63) == 0) burst = ~burst;
                tx_gap = burst ? 0 : $urandom_range(0, 12);
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // output side: stall and check
    always @(posedge clk) begin
        vertex_t ex;
        if (m_tvalid && m_tready) begin
            if (vertex_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transaction %h", m_tdata);
            end else begin
                ex = vertex_queue.pop_front();
                if (m_tdata[0] !== ex.found || m_tdata[4:1] !== ex.cnt ||
                    m_tdata[36:5] !== ex.vx || m_tdata[68:37] !== ex.vy ||
                    m_tdata[100:69] !== ex.vz) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp f=%0d c=%0d x=%h y=%h z=%h got f=%0d c=%0d x=%h y=%h z=%h",
                                 ex.found, ex.cnt, ex.vx, ex.vy, ex.vz, m_tdata[0],
                                 m_tdata[4:1], m_tdata[36:5], m_tdata[68:37], m_tdata[100:69]);
                end
            end
            rx_gap = burst ? 0 : $urandom_range(0, 12);
        end
        if (rx_hold || !rst_n) begin
            m_tready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    initial begin
        wait (accepted > 300);
        @(posedge clk);
        rx_hold <= 1;
        repeat (300) @(posedge clk);
        rx_hold <= 0;
    end

    initial begin
        #600000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int d[8];
        int cfgs[7][4];
        origin[0] = 0; origin[1] = 0; origin[2] = 0;
        scale = 256;
        cfgs = '{'{1023, -1024, 5, 65535}, '{-1024, 1023, -1, 1}, '{300, -7, 1023, 0},
                 '{-1024, -1024, -1024, 65535}, '{1023, 1023, 1023, 65535},
                 '{17, -300, 0, 128}, '{0, 0, 0, 256}};
        repeat (9) @(posedge clk);
        rst_n <= 1;

        d = '{0, 0, 0, 0, 0, 0, 0, 0};
        cell_queue.push_back(pack_cell(0, 0, 0, d));
        d = '{5, 5, 5, 5, 5, 5, 5, 5};
        cell_queue.push_back(pack_cell(31, 31, 31, d));
        d = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        cell_queue.push_back(pack_cell(31, 0, 31, d));
        d = '{32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768};
        cell_queue.push_back(pack_cell(0, 31, 0, d));
        d = '{0, 9, 9, 9, 9, 9, 9, 9};
        cell_queue.push_back(pack_cell(7, 8, 9, d));
        d = '{-1, -1, -1, -1, -1, -1, -1, 1};
        cell_queue.push_back(pack_cell(31, 31, 31, d));
        d = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        cell_queue.push_back(pack_cell(3, 2, 1, d));
        d = '{0, 0, 4, -4, 0, 0, 0, 0};
        cell_queue.push_back(pack_cell(16, 16, 16, d));
        d = '{-100, 100, -200, 300, 50, -50, 1, -1};
        cell_queue.push_back(pack_cell(10, 20, 30, d));
        push_random(180);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            set_config(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
            d = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
            cell_queue.push_back(pack_cell(31, 31, 31, d));
            d = '{0, 0, 0, 0, 0, 0, 0, 0};
            cell_queue.push_back(pack_cell(0, 0, 0, d));
            push_random(160);
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && vertex_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/snv_pkg.sv
rtl/snv_cross_div.sv
rtl/snv_avg_div.sv
rtl/snv_world.sv
rtl/surface_nets_cell_vertex.sv
test/tb_top.sv
